/* rtl/ip_address_text_formatter_top_assert.svh */
// Assertion macros shared by the address formatter RTL.
`ifndef IP_ADDRESS_TEXT_FORMATTER_TOP_ASSERT_SVH
`define IP_ADDRESS_TEXT_FORMATTER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IPFMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define IPFMT_NEVER(lbl, cond, msg) \
  `IPFMT_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/ipfmt_pkg.sv */
`timescale 1ns / 1ps

package ipfmt_pkg;

  // Address family codes carried on the mode input.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_V4,
    MODE_V6,
    MODE_BAD
  } mode_e;

  // Zero-run scanner control and result.
  typedef struct packed {
    logic clear;
    logic step;
    logic zero;
  } zs_ctrl_t;

  typedef struct packed {
    logic [3:0] best_len;
    logic [2:0] best_pos;
  } zs_stat_t;

  // Decimal digit shifter control and result.
  typedef struct packed {
    logic       load;
    logic       shift;
    logic [7:0] value;
  } dec_ctrl_t;

  typedef struct packed {
    logic [3:0] digit;
    logic       last;
  } dec_stat_t;

  // Convert one byte to three BCD digits (shift-and-add-3).
  function automatic logic [11:0] bin2bcd(input logic [7:0] v);
    logic [19:0] s;
    s = {12'h000, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = {s[18:0], 1'b0};
    end
    return s[19:8];
  endfunction

endpackage

/* rtl/ipfmt_zscan.sv */
`timescale 1ns / 1ps

// Serial zero-run finder: one 16-bit group flag per step, left to right.
module ipfmt_zscan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ipfmt_pkg::zs_ctrl_t ctrl_i,
  output ipfmt_pkg::zs_stat_t stat_o
);

  logic [2:0] idx_q;
  logic [3:0] cur_len_q;
  logic [2:0] cur_start_q;
  logic [3:0] best_len_q;
  logic [2:0] best_pos_q;
  logic [3:0] run_len;
  logic [2:0] run_start;

  // Extend the open run by the current group.
  assign run_len   = cur_len_q + 4'd1;
  assign run_start = (cur_len_q == 4'd0) ? idx_q : cur_start_q;

  // Track the current run and keep the first strictly longest one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cur_len_q   <= '0;
      cur_start_q <= '0;
      best_len_q  <= '0;
      best_pos_q  <= '0;
    end else if (ctrl_i.clear) begin
      idx_q       <= '0;
      cur_len_q   <= '0;
      cur_start_q <= '0;
      best_len_q  <= '0;
      best_pos_q  <= '0;
    end else if (ctrl_i.step) begin
      idx_q <= idx_q + 3'd1;
      if (ctrl_i.zero) begin
        cur_len_q   <= run_len;
        cur_start_q <= run_start;
        if (run_len > best_len_q) begin
          best_len_q <= run_len;
          best_pos_q <= run_start;
        end
      end else begin
        cur_len_q <= '0;
      end
    end
  end

  assign stat_o.best_len = best_len_q;
  assign stat_o.best_pos = best_pos_q;

endmodule

/* rtl/ipfmt_dec.sv */
`timescale 1ns / 1ps

// Decimal digit shifter: loads a byte, hands out its digits one per step
// without leading zeros.
module ipfmt_dec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipfmt_pkg::dec_ctrl_t ctrl_i,
  output ipfmt_pkg::dec_stat_t stat_o
);

  logic [11:0] bcd;
  logic [11:0] bcd_q;
  logic [1:0]  cnt_q;

  assign bcd = ipfmt_pkg::bin2bcd(ctrl_i.value);

  // Align the first significant digit at the top; count digits left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      if (bcd[11:8] != 4'h0) begin
        bcd_q <= bcd;
        cnt_q <= 2'd2;
      end else if (bcd[7:4] != 4'h0) begin
        bcd_q <= {bcd[7:0], 4'h0};
        cnt_q <= 2'd1;
      end else begin
        bcd_q <= {bcd[3:0], 8'h00};
        cnt_q <= 2'd0;
      end
    end else if (ctrl_i.shift) begin
      bcd_q <= {bcd_q[7:0], 4'h0};
      if (cnt_q != 2'd0) cnt_q <= cnt_q - 2'd1;
    end
  end

  assign stat_o.digit = bcd_q[11:8];
  assign stat_o.last  = (cnt_q == 2'd0);

endmodule

/* rtl/ip_address_text_formatter_top.sv */
`timescale 1ns / 1ps

// IP address text formatter.
// An item is taken at a rising edge with start_i high and busy_o low; busy_o
// stays high until the item's last result is produced. The text comes out one
// ASCII character per result on text_char_o, each valid for exactly one cycle
// with result_valid_o; last_char_o marks the final one, status_o flags an
// unsupported family (one result, character 0, no text).
// Timing: at most one character leaves per cycle. Each generated character
// waits in a holding register until the next one or the end of the item, so
// the final one can be flagged. For IPv6 the serial zero-run scan covers the
// eight groups (one group per cycle) before any text starts.
// A new item is taken in the cycle after busy_o falls.
// The receiver cannot stall: results are never held back.
// Reset clears the sequencer and drops any item in flight.
module ip_address_text_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  prefix_length_i,
  input  logic        show_prefix_i,
  output logic        result_valid_o,
  output logic [7:0]  text_char_o,
  output logic        last_char_o,
  output logic        status_o
);

  `include "ip_address_text_formatter_top_assert.svh"

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NONE,
    S_SCAN,
    S_V6_GRP,
    S_V6_HEX,
    S_DEC,
    S_V4_DOT,
    S_SLASH,
    S_FIN
  } state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
  endfunction

  function automatic logic [7:0] none_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h6e;
      2'd1:    c = 8'h6f;
      2'd2:    c = 8'h6e;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  state_e       state_q, state_d;
  logic [127:0] sr_q, sr_d;
  logic [3:0]   grp_q, grp_d;
  logic [1:0]   nib_q, nib_d;
  logic [1:0]   oct_q, oct_d;
  logic         tail_q, tail_d;
  logic         show_q, show_d;
  logic [7:0]   prefix_q, prefix_d;
  logic         pfx_q, pfx_d;
  logic         err_q, err_d;
  logic         pend_v_q, pend_v_d;
  logic [7:0]   pend_c_q, pend_c_d;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_char_q, out_char_d;
  logic         out_last_q, out_last_d;
  logic         out_status_q, out_status_d;

  logic         gen;
  logic [7:0]   gen_char;
  logic         fin;
  logic [1:0]   lz;
  logic         compress;

  ipfmt_pkg::zs_ctrl_t  zs_ctrl;
  ipfmt_pkg::zs_stat_t  zs_stat;
  ipfmt_pkg::dec_ctrl_t dec_ctrl;
  ipfmt_pkg::dec_stat_t dec_stat;

  ipfmt_zscan u_zscan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (zs_ctrl),
    .stat_o (zs_stat)
  );

  ipfmt_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dec_ctrl),
    .stat_o (dec_stat)
  );

  // Count leading zero nibbles of the current group, keeping at least one.
  always_comb begin
    if (sr_q[127:124] != 4'h0)      lz = 2'd0;
    else if (sr_q[123:120] != 4'h0) lz = 2'd1;
    else if (sr_q[119:116] != 4'h0) lz = 2'd2;
    else                            lz = 2'd3;
  end

  assign compress = (zs_stat.best_len > 4'd1);

  // Sequence the text: one character generated per cycle at most.
  always_comb begin
    state_d  = state_q;
    sr_d     = sr_q;
    grp_d    = grp_q;
    nib_d    = nib_q;
    oct_d    = oct_q;
    tail_d   = tail_q;
    show_d   = show_q;
    prefix_d = prefix_q;
    pfx_d    = pfx_q;
    err_d    = err_q;
    gen      = 1'b0;
    gen_char = CH_ZERO;
    fin      = 1'b0;
    zs_ctrl  = '0;
    dec_ctrl = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          show_d   = show_prefix_i;
          prefix_d = prefix_length_i;
          pfx_d    = 1'b0;
          err_d    = 1'b0;
          case (ipfmt_pkg::mode_e'(mode_i))
            ipfmt_pkg::MODE_NONE: begin
              nib_d   = 2'd0;
              state_d = S_NONE;
            end
            ipfmt_pkg::MODE_V4: begin
              dec_ctrl.load  = 1'b1;
              dec_ctrl.value = addr_low_i[31:24];
              sr_d           = {addr_low_i[23:0], 104'h0};
              oct_d          = 2'd0;
              state_d        = S_DEC;
            end
            ipfmt_pkg::MODE_V6: begin
              sr_d          = {addr_high_i, addr_low_i};
              zs_ctrl.clear = 1'b1;
              grp_d         = 4'd0;
              state_d       = S_SCAN;
            end
            default: begin
              err_d   = 1'b1;
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_NONE: begin
        gen      = 1'b1;
        gen_char = none_char(nib_q);
        nib_d    = nib_q + 2'd1;
        if (nib_q == 2'd3) state_d = S_FIN;
      end

      // Rotate the groups past the scanner; eight steps restore the order.
      S_SCAN: begin
        zs_ctrl.step = 1'b1;
        zs_ctrl.zero = (sr_q[127:112] == 16'h0000);
        sr_d         = {sr_q[111:0], sr_q[127:112]};
        grp_d        = grp_q + 4'd1;
        if (grp_q == 4'd7) begin
          grp_d   = 4'd0;
          tail_d  = 1'b0;
          state_d = S_V6_GRP;
        end
      end

      S_V6_GRP: begin
        if (grp_q[3]) begin
          // Close a run that reaches the end with a second colon.
          if (tail_q) begin
            gen      = 1'b1;
            gen_char = CH_COLON;
          end
          state_d = show_q ? S_SLASH : S_FIN;
        end else if (compress && (grp_q[2:0] == zs_stat.best_pos)) begin
          // Drop the whole zero run behind a single colon.
          gen      = 1'b1;
          gen_char = CH_COLON;
          tail_d   = 1'b1;
          grp_d    = grp_q + zs_stat.best_len;
          sr_d     = sr_q << {zs_stat.best_len, 4'h0};
        end else begin
          if (grp_q != 4'd0) begin
            gen      = 1'b1;
            gen_char = CH_COLON;
          end
          sr_d    = sr_q << {lz, 2'b00};
          nib_d   = 2'd3 - lz;
          state_d = S_V6_HEX;
        end
      end

      S_V6_HEX: begin
        gen      = 1'b1;
        gen_char = hex_char(sr_q[127:124]);
        sr_d     = {sr_q[123:0], 4'h0};
        if (nib_q == 2'd0) begin
          grp_d   = grp_q + 4'd1;
          tail_d  = 1'b0;
          state_d = S_V6_GRP;
        end else begin
          nib_d = nib_q - 2'd1;
        end
      end

      S_DEC: begin
        gen            = 1'b1;
        gen_char       = {4'h3, dec_stat.digit};
        dec_ctrl.shift = 1'b1;
        if (dec_stat.last) begin
          if (pfx_q)               state_d = S_FIN;
          else if (oct_q == 2'd3)  state_d = show_q ? S_SLASH : S_FIN;
          else                     state_d = S_V4_DOT;
        end
      end

      S_V4_DOT: begin
        gen            = 1'b1;
        gen_char       = CH_DOT;
        dec_ctrl.load  = 1'b1;
        dec_ctrl.value = sr_q[127:120];
        sr_d           = {sr_q[119:0], 8'h00};
        oct_d          = oct_q + 2'd1;
        state_d        = S_DEC;
      end

      S_SLASH: begin
        gen            = 1'b1;
        gen_char       = CH_SLASH;
        dec_ctrl.load  = 1'b1;
        dec_ctrl.value = prefix_q;
        pfx_d          = 1'b1;
        state_d        = S_DEC;
      end

      S_FIN: begin
        fin     = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold each character until the next one or the end of the item so the final one can be flagged.
  always_comb begin
    pend_v_d     = pend_v_q;
    pend_c_d     = pend_c_q;
    out_valid_d  = 1'b0;
    out_char_d   = pend_c_q;
    out_last_d   = 1'b0;
    out_status_d = 1'b0;
    if (gen) begin
      out_valid_d = pend_v_q;
      pend_v_d    = 1'b1;
      pend_c_d    = gen_char;
    end else if (fin) begin
      pend_v_d = 1'b0;
      if (err_q) begin
        out_valid_d  = 1'b1;
        out_char_d   = 8'h00;
        out_last_d   = 1'b1;
        out_status_d = 1'b1;
      end else begin
        out_valid_d = pend_v_q;
        out_last_d  = 1'b1;
      end
    end
  end

  // Hold sequencer state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      grp_q        <= '0;
      nib_q        <= '0;
      oct_q        <= '0;
      tail_q       <= 1'b0;
      show_q       <= 1'b0;
      prefix_q     <= '0;
      pfx_q        <= 1'b0;
      err_q        <= 1'b0;
      pend_v_q     <= 1'b0;
      pend_c_q     <= '0;
      out_valid_q  <= 1'b0;
      out_char_q   <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      grp_q        <= grp_d;
      nib_q        <= nib_d;
      oct_q        <= oct_d;
      tail_q       <= tail_d;
      show_q       <= show_d;
      prefix_q     <= prefix_d;
      pfx_q        <= pfx_d;
      err_q        <= err_d;
      pend_v_q     <= pend_v_d;
      pend_c_q     <= pend_c_d;
      out_valid_q  <= out_valid_d;
      out_char_q   <= out_char_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

  // Advance the address shift register.
  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = out_valid_q;
  assign text_char_o    = out_char_q;
  assign last_char_o    = out_last_q;
  assign status_o       = out_status_q;

  `IPFMT_ASSERT(a_result_needs_item, result_valid_o |-> $past(busy_o), "result without item")
  `IPFMT_ASSERT(a_last_is_valid, last_char_o |-> result_valid_o, "last flag without result")
  `IPFMT_ASSERT(a_error_form, status_o |-> (last_char_o && text_char_o == 8'h00), "bad error")
  `IPFMT_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "item taken but not busy")
  `IPFMT_NEVER(a_idle_pending, pend_v_q && (state_q == S_IDLE), "character left pending")

endmodule

/* bench/ipfmt_text_checker.sv */
`timescale 1ns / 1ps

module ipfmt_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [63:0] addr_high_i,
  input  logic [63:0] addr_low_i,
  input  logic [7:0]  prefix_length_i,
  input  logic        show_prefix_i,
  input  logic        result_valid_i,
  input  logic [7:0]  text_char_i,
  input  logic        last_char_i,
  input  logic        status_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          chars_checked_o
);

  // One expected result: character, final flag and status.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       status;
  } text_result_t;

  text_result_t text_expected[$];
  logic [7:0]   line_buf[$];
  text_result_t want;
  int           mismatches = 0;
  int           chars_seen = 0;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    chars_checked_o = 0;
  end

  // Print one line per mismatch and count it.
  task automatic note_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    mismatches++;
  endtask

  // Append an 8-bit value in decimal without leading zeros.
  function automatic void put_decimal(input logic [7:0] v);
    if (v >= 8'd100) line_buf.push_back("0" + v / 8'd100);
    if (v >= 8'd10) line_buf.push_back("0" + (v / 8'd10) % 8'd10);
    line_buf.push_back("0" + v % 8'd10);
  endfunction

  // Work out the text of one address item and queue its characters.
  function automatic void predict_text(input ipfmt_pkg::mode_e mode, input logic [63:0] hi,
                                       input logic [63:0] lo, input logic [7:0] prefix,
                                       input logic show);
    logic [15:0]  grp[8];
    int           run[8];
    int           best_pos;
    int           best_len;
    int           i;
    int           sh;
    bit           tail;
    bit           started;
    logic [3:0]   d;
    text_result_t r;
    line_buf.delete();
    if (mode == ipfmt_pkg::MODE_BAD) begin
      r.ch = 8'h00;
      r.last = 1'b1;
      r.status = 1'b1;
      text_expected.push_back(r);
      return;
    end
    if (mode == ipfmt_pkg::MODE_NONE) begin
      line_buf.push_back("n");
      line_buf.push_back("o");
      line_buf.push_back("n");
      line_buf.push_back("e");
    end else begin
      if (mode == ipfmt_pkg::MODE_V4) begin
        put_decimal(lo[31:24]);
        line_buf.push_back(".");
        put_decimal(lo[23:16]);
        line_buf.push_back(".");
        put_decimal(lo[15:8]);
        line_buf.push_back(".");
        put_decimal(lo[7:0]);
      end else begin
        // Split into groups and find the first longest zero run.
        for (i = 0; i < 4; i++) begin
          grp[i]     = hi[63 - 16 * i -: 16];
          grp[i + 4] = lo[63 - 16 * i -: 16];
        end
        for (i = 7; i >= 0; i--) begin
          if (grp[i] == 16'h0000) run[i] = 1 + ((i < 7) ? run[i + 1] : 0);
          else run[i] = 0;
        end
        best_pos = -1;
        best_len = 0;
        for (i = 0; i < 8; i++) begin
          if (run[i] > best_len) begin
            best_len = run[i];
            best_pos = i;
          end
        end
        tail = 1'b0;
        i = 0;
        while (i < 8) begin
          if (i == best_pos && best_len > 1) begin
            line_buf.push_back(":");
            i += best_len;
            tail = 1'b1;
          end else begin
            if (i != 0) line_buf.push_back(":");
            started = 1'b0;
            for (sh = 12; sh >= 0; sh -= 4) begin
              d = grp[i][sh +: 4];
              if (d != 4'h0 || started || sh == 0) begin
                line_buf.push_back((d < 4'd10) ? ("0" + d) : ("a" + d - 8'd10));
                started = 1'b1;
              end
            end
            tail = 1'b0;
            i++;
          end
        end
        if (tail) line_buf.push_back(":");
      end
      if (show) begin
        line_buf.push_back("/");
        put_decimal(prefix);
      end
    end
    foreach (line_buf[k]) begin
      r.ch = line_buf[k];
      r.last = (k == line_buf.size() - 1);
      r.status = 1'b0;
      text_expected.push_back(r);
    end
  endfunction

  // Compare each result with the oldest expectation, then take new items.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i) begin
        if (text_expected.size() == 0) begin
          note_mismatch($sformatf("result %02h with nothing expected", text_char_i));
        end else begin
          want = text_expected.pop_front();
          if (text_char_i !== want.ch)
            note_mismatch($sformatf("text_char %02h, expected %02h", text_char_i, want.ch));
          if (last_char_i !== want.last)
            note_mismatch($sformatf("last_char %b, expected %b on char %02h",
                                    last_char_i, want.last, want.ch));
          if (status_i !== want.status)
            note_mismatch($sformatf("status %b, expected %b", status_i, want.status));
          chars_seen++;
        end
      end
      if (start_i && !busy_i)
        predict_text(ipfmt_pkg::mode_e'(mode_i), addr_high_i, addr_low_i, prefix_length_i,
                     show_prefix_i);
    end
    fail_count_o    <= mismatches;
    pending_o       <= text_expected.size();
    chars_checked_o <= chars_seen;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  mode_i = 2'b00;
  logic [63:0] addr_high_i = '0;
  logic [63:0] addr_low_i = '0;
  logic [7:0]  prefix_length_i = '0;
  logic        show_prefix_i = 1'b0;
  logic        busy_o;
  logic        result_valid_o;
  logic [7:0]  text_char_o;
  logic        last_char_o;
  logic        status_o;

  int fail_count;
  int pending_chars;
  int chars_checked;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int n_none = 0;
  int n_v4 = 0;
  int n_v6 = 0;
  int n_bad = 0;

  ip_address_text_formatter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .addr_high_i     (addr_high_i),
    .addr_low_i      (addr_low_i),
    .prefix_length_i (prefix_length_i),
    .show_prefix_i   (show_prefix_i),
    .result_valid_o  (result_valid_o),
    .text_char_o     (text_char_o),
    .last_char_o     (last_char_o),
    .status_o        (status_o)
  );

  ipfmt_text_checker text_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .mode_i          (mode_i),
    .addr_high_i     (addr_high_i),
    .addr_low_i      (addr_low_i),
    .prefix_length_i (prefix_length_i),
    .show_prefix_i   (show_prefix_i),
    .result_valid_i  (result_valid_o),
    .text_char_i     (text_char_o),
    .last_char_i     (last_char_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_chars),
    .chars_checked_o (chars_checked)
  );

  always #6 clk_i = ~clk_i;

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one address item, idle first at the sender rate, hold until taken.
  task automatic send_address(input ipfmt_pkg::mode_e mode, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [7:0] prefix,
                              input logic show);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    mode_i          <= mode;
    addr_high_i     <= hi;
    addr_low_i      <= lo;
    prefix_length_i <= prefix;
    show_prefix_i   <= show;
    do @(posedge clk_i); while (busy_o);
    case (mode)
      ipfmt_pkg::MODE_NONE: n_none++;
      ipfmt_pkg::MODE_V4:   n_v4++;
      ipfmt_pkg::MODE_V6:   n_v6++;
      default:              n_bad++;
    endcase
  endtask

  // Drop start and wait until every expected character has come out.
  task automatic drain_text;
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars != 0);
  endtask

  // Random item: mostly well-formed addresses with shaped groups and octets.
  task automatic send_random_address;
    logic [127:0]      a6;
    logic [15:0]       g;
    logic [15:0]       masks[4];
    logic [7:0]        octet;
    logic [31:0]       v4;
    int                zero_pct;
    int                pick;
    ipfmt_pkg::mode_e  mode;
    logic [7:0]        prefix;
    masks = '{16'h000f, 16'h00ff, 16'h0fff, 16'hffff};
    pick = $urandom_range(0, 99);
    if (pick < 10) mode = ipfmt_pkg::MODE_NONE;
    else if (pick < 18) mode = ipfmt_pkg::MODE_BAD;
    else if (pick < 48) mode = ipfmt_pkg::MODE_V4;
    else mode = ipfmt_pkg::MODE_V6;
    prefix = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 128)) : 8'($urandom_range(0, 255));
    a6 = {$urandom, $urandom, $urandom, $urandom};
    if (mode == ipfmt_pkg::MODE_V6) begin
      zero_pct = 30 * $urandom_range(0, 3);
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 99) < zero_pct) g = 16'h0000;
        else g = 16'($urandom) & masks[$urandom_range(0, 3)];
        a6 = {a6[111:0], g};
      end
    end else if (mode == ipfmt_pkg::MODE_V4) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 2))
          0:       octet = 8'($urandom_range(0, 9));
          1:       octet = 8'($urandom_range(10, 99));
          default: octet = 8'($urandom_range(100, 255));
        endcase
        v4 = {v4[23:0], octet};
      end
      a6[31:0] = v4;
    end
    send_address(mode, a6[127:64], a6[63:0], prefix, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int idle_by_phase[3];
    idle_by_phase = '{9, 67, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each family, prefix extremes, zero-run corner cases.
    sender_idle_pct = 9;
    send_address(ipfmt_pkg::MODE_NONE, '0, '0, 8'd0, 1'b0);
    send_address(ipfmt_pkg::MODE_NONE, '1, '1, 8'd255, 1'b1);
    send_address(ipfmt_pkg::MODE_BAD, '1, '1, 8'd255, 1'b1);
    send_address(ipfmt_pkg::MODE_BAD, '0, '0, 8'd0, 1'b0);
    send_address(ipfmt_pkg::MODE_V4, '0, '0, 8'd0, 1'b1);
    send_address(ipfmt_pkg::MODE_V4, '1, '1, 8'd255, 1'b1);
    send_address(ipfmt_pkg::MODE_V4, 64'h0123_4567_89ab_cdef, 64'hdead_beef_0a00_6409, 8'd24,
                 1'b1);
    send_address(ipfmt_pkg::MODE_V4, '0, 64'h0000_0000_6309_0a64, 8'd99, 1'b1);
    send_address(ipfmt_pkg::MODE_V4, '0, 64'h0000_0000_c0a8_0101, 8'd100, 1'b0);
    send_address(ipfmt_pkg::MODE_V6, '0, '0, 8'd0, 1'b0);
    send_address(ipfmt_pkg::MODE_V6, '0, '0, 8'd10, 1'b1);
    send_address(ipfmt_pkg::MODE_V6, '1, '1, 8'd128, 1'b1);
    send_address(ipfmt_pkg::MODE_V6, '1, '1, 8'd255, 1'b1);
    send_address(ipfmt_pkg::MODE_V6, 64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001, 8'd64,
                 1'b1);
    send_address(ipfmt_pkg::MODE_V6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007, 8'd9,
                 1'b1);
    send_address(ipfmt_pkg::MODE_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0003_0004, 8'd48,
                 1'b0);
    send_address(ipfmt_pkg::MODE_V6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003, 8'd48,
                 1'b1);
    send_address(ipfmt_pkg::MODE_V6, '0, 64'h0000_0000_0000_0001, 8'd128, 1'b1);
    send_address(ipfmt_pkg::MODE_V6, 64'h0001_0000_0000_0000, '0, 8'd16, 1'b1);
    send_address(ipfmt_pkg::MODE_V6, 64'h0abc_00de_000f_f000, 64'h8000_0800_0080_0008, 8'd1,
                 1'b0);
    drain_text();

    // Random phases with different sender idle rates.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      repeat (130) send_random_address();
      drain_text();
    end

    // Let any trailing results settle before the verdict.
    repeat (16) @(posedge clk_i);
    $display("Covered %0d address items: %0d none, %0d IPv4, %0d IPv6, %0d unsupported.",
             n_none + n_v4 + n_v6 + n_bad, n_none, n_v4, n_v6, n_bad);
    $display("Checked %0d characters over sender idle rates of 9, 67 and 0 percent.",
             chars_checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ipfmt_pkg.sv
rtl/ipfmt_zscan.sv
rtl/ipfmt_dec.sv
rtl/ip_address_text_formatter_top.sv
bench/ipfmt_text_checker.sv
bench/tb.sv
